>>> rtl/assert_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CPF_ASSERT(lbl, prop, msg)
`define CPF_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/cpf_pkg.sv
// Types, constants and the CRC byte update for the CRC-16 packet framer.
package cpf_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int LEN_W       = 11;
  localparam int CRC_W       = 16;

  localparam logic [7:0]       SOH_BYTE = 8'h01;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam logic CMD_OPEN = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_SOH     = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LEN_HI  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LEN_LO  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_BODY    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_CRC_HI  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CRC_LO  = 3'd5;

  typedef struct packed {
    logic             hdr;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic [CRC_W-1:0] crc;
    logic             crc_follow;
  } job_t;

  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0] byte_in);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {byte_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/cpf_front.sv
// Front end: classify input words, track the open frame and fold the CRC.
module cpf_front import cpf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             command,
  input  logic [LEN_W-1:0] frame_length,
  input  logic [7:0]       data_byte,
  output logic             job_push,
  output job_t             job
);

  localparam logic [16:0]      MAX_CMP = 17'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  logic [LEN_W-1:0] remaining_r, remaining_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic             open_r, open_nxt;

  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] rem_dec;
  logic [CRC_W-1:0] crc_new;

  always_comb begin
    len_sat = ({6'd0, frame_length} > MAX_CMP) ? MAX_LEN : frame_length;
    rem_dec = remaining_r - LEN_W'(1);
    crc_new = crc_fold(crc_r, data_byte);

    remaining_nxt = remaining_r;
    crc_nxt       = crc_r;
    open_nxt      = open_r;
    job_push      = 1'b0;
    job.hdr        = (command == CMD_OPEN);
    job.len        = len_sat;
    job.data       = data_byte;
    job.crc        = '0;
    job.crc_follow = 1'b0;

    if (accept) begin
      case (command)
        CMD_OPEN: begin
          job_push       = 1'b1;
          job.crc_follow = (len_sat == '0);
          crc_nxt        = '0;
          remaining_nxt  = len_sat;
          open_nxt       = (len_sat != '0);
        end
        CMD_DATA: begin
          if (open_r) begin
            job_push       = 1'b1;
            job.crc        = crc_new;
            job.crc_follow = (rem_dec == '0);
            if (rem_dec == '0) begin
              crc_nxt       = '0;
              remaining_nxt = '0;
              open_nxt      = 1'b0;
            end else begin
              crc_nxt       = crc_new;
              remaining_nxt = rem_dec;
            end
          end
        end
        default: begin
          job_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      crc_r       <= '0;
      open_r      <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      crc_r       <= crc_nxt;
      open_r      <= open_nxt;
    end
  end

endmodule

>>> rtl/cpf_job_queue.sv
// Short job queue between the front and back ends.
module cpf_job_queue import cpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wjob,
  output logic full,
  input  logic pop,
  output job_t rjob,
  output logic valid
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rjob    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wjob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/cpf_back.sv
// Back end: expand jobs into line bytes and hold the output word.
module cpf_back import cpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_tx_byte,
  output logic       out_end_of_frame,
  output logic       out_last_in_run
);

  logic              out_valid_r;
  logic [7:0]        tx_r;
  logic              eof_r, last_r;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [STEP_W-1:0] eff_step, last_step;
  logic              take, done;
  logic [7:0]        len_hi, len_lo, sel_byte;

  always_comb begin
    eff_step  = (!job.hdr && step_r == STEP_SOH) ? STEP_BODY : step_r;
    last_step = job.crc_follow ? STEP_CRC_LO : STEP_BODY;
    done      = (eff_step == last_step);
    take      = job_valid && (!out_valid_r || out_pop);
    job_pop   = take && done;
    len_hi    = {5'd0, job.len[LEN_W-1:8]};
    len_lo    = job.len[7:0];
    step_nxt  = done ? STEP_SOH : eff_step + STEP_W'(1);
    case (eff_step)
      STEP_SOH:    sel_byte = SOH_BYTE;
      STEP_LEN_HI: sel_byte = len_hi;
      STEP_LEN_LO: sel_byte = len_lo;
      STEP_BODY:   sel_byte = job.hdr ? (len_hi + len_lo) : job.data;
      STEP_CRC_HI: sel_byte = job.crc[15:8];
      STEP_CRC_LO: sel_byte = job.crc[7:0];
      default:     sel_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= STEP_SOH;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        step_r      <= step_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tx_r   <= sel_byte;
      eof_r  <= done && job.crc_follow;
      last_r <= done;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_tx_byte      = tx_r;
  assign out_end_of_frame = eof_r;
  assign out_last_in_run  = last_r;

endmodule

>>> rtl/crc16_packet_framer_unit.sv
// Top level of the CRC-16 packet framer.
// Push a start word to open a frame: it yields SOH, length high, length low
// and their 8-bit sum, plus CRC 0x0000 when the length is zero. Each data
// word yields its byte, and the last payload byte of a frame is followed by
// the CRC-16/XMODEM, high byte first. Data outside a frame is dropped. The
// front end takes one word per cycle while its four-entry job queue has room;
// the back end sends one byte per cycle while pop drains the output, so a data
// stream runs at one word per cycle and a header job yields four to six bytes.
`include "assert_macros.svh"
module crc16_packet_framer_unit import cpf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_command,
  input  logic [LEN_W-1:0] in_frame_length,
  input  logic [7:0]       in_data_byte,
  output logic             out_empty,
  input  logic             pop,
  output logic [7:0]       out_tx_byte,
  output logic             out_end_of_frame,
  output logic             out_last_in_run
);

  logic accept;
  logic q_push, q_full, q_pop, q_valid;
  job_t q_wjob, q_rjob;
  logic out_pop;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign out_pop = pop && !out_empty;

  cpf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .command      (in_command),
    .frame_length (in_frame_length),
    .data_byte    (in_data_byte),
    .job_push     (q_push),
    .job          (q_wjob)
  );

  cpf_job_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wjob  (q_wjob),
    .full  (q_full),
    .pop   (q_pop),
    .rjob  (q_rjob),
    .valid (q_valid)
  );

  cpf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_valid),
    .job              (q_rjob),
    .job_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_tx_byte      (out_tx_byte),
    .out_end_of_frame (out_end_of_frame),
    .out_last_in_run  (out_last_in_run)
  );

  `CPF_ASSERT_NEVER(a_no_queue_overflow, q_push && q_full, "job pushed into full queue")
  `CPF_ASSERT(a_eof_is_last, (!out_empty && out_end_of_frame) |-> out_last_in_run, "eof not last")
  `CPF_ASSERT(a_empty_hdr_has_crc, (q_push && q_wjob.hdr) |-> (q_wjob.crc_follow == (q_wjob.len == '0)), "zero-length header crc mismatch")

endmodule
